>>> hdl/dtp_pkg.sv
// Drain tank pump controller: shared types, codes and reset constants.
// No dependencies; used by dtp_step and drain_tank_pump_controller.
package dtp_pkg;

  // drain level codes
  localparam logic [1:0] LVL_LOW     = 2'd0;
  localparam logic [1:0] LVL_MID     = 2'd1;
  localparam logic [1:0] LVL_HIGH    = 2'd2;
  localparam logic [1:0] LVL_ERR_LOW = 2'd3;

  // pump command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // configuration register indexes
  localparam int unsigned IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_RO_TANK_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_INIT_DRAIN_LIMIT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_STALE_WATER_LIMIT = 3'd2;
  localparam logic [IDX_W-1:0] REG_ERROR_LOW_MIN_ON  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOAD_CHECK_MIN_ON = 3'd4;

  localparam int unsigned DATA_W = 17;

  // reset values
  localparam logic [4:0]  STARTUP_TICKS       = 5'd30;
  localparam logic [9:0]  INIT_DRAIN_RESET    = 10'd200;
  localparam logic [16:0] STALE_LIMIT_RESET   = 17'd108000;
  localparam logic [9:0]  ERR_LOW_MIN_RESET   = 10'd300;
  localparam logic [9:0]  LOAD_CHECK_RESET    = 10'd150;

  typedef struct packed {
    logic        ro_tank_mode;
    logic [9:0]  init_drain_limit;
    logic [16:0] stale_water_limit;
    logic [9:0]  error_low_min_on;
    logic [9:0]  load_check_min_on;
  } cfg_t;

  typedef struct packed {
    logic [1:0] drain_level;
    logic       pump_is_on;
    logic       pump_loaded;
    logic       cold_low;
    logic       room_low;
    logic       bin_full;
    logic       start_init;
  } item_t;

  typedef struct packed {
    logic [4:0]  startup_hold;
    logic        init_finished;
    logic [9:0]  init_run_ticks;
    logic [1:0]  stored_level;
    logic [16:0] stale_count;
    logic [9:0]  error_low_count;
    logic [9:0]  load_check_count;
    logic        prev_bin_full;
  } state_t;

  typedef struct packed {
    logic [1:0] pump_command;
    logic       init_done;
    logic [1:0] level_seen;
  } result_t;

endpackage

>>> hdl/dtp_step.sv
// Drain tank pump controller: per-tick decision logic (combinational).
// Takes current state, config and one item; gives next state and result. Uses dtp_pkg.
module dtp_step (
  input  dtp_pkg::cfg_t    cfg,
  input  dtp_pkg::state_t  cur,
  input  dtp_pkg::item_t   item,
  output dtp_pkg::state_t  nxt,
  output dtp_pkg::result_t res
);

  logic [10:0] run_next;
  logic [1:0]  cmd;

  assign run_next = {1'b0, cur.init_run_ticks} + 11'd1;

  always_comb begin
    nxt = cur;
    cmd = dtp_pkg::CMD_NONE;

    if (item.start_init) begin
      nxt.init_finished = 1'b0;
    end

    if (cur.startup_hold != 5'd0) begin
      nxt.startup_hold = cur.startup_hold - 5'd1;
    end else begin
      nxt.stored_level = item.drain_level;
      if (!nxt.init_finished) begin
        // initial drain phase
        if (item.pump_is_on) begin
          if (!item.pump_loaded || run_next > {1'b0, cfg.init_drain_limit}) begin
            cmd                = dtp_pkg::CMD_OFF;
            nxt.init_run_ticks = 10'd0;
            nxt.init_finished  = 1'b1;
          end else begin
            nxt.init_run_ticks = run_next[9:0];
          end
        end
        if (cfg.ro_tank_mode) begin
          if (item.drain_level != dtp_pkg::LVL_LOW || (item.cold_low && item.room_low)) begin
            cmd = dtp_pkg::CMD_ON;
          end else begin
            nxt.init_finished = 1'b1;
          end
        end else begin
          cmd = dtp_pkg::CMD_ON;
        end
      end else if (!item.pump_is_on) begin
        // pump idle: look for a reason to start
        nxt.load_check_count = cfg.load_check_min_on;
        if (item.drain_level == dtp_pkg::LVL_HIGH) begin
          cmd = dtp_pkg::CMD_ON;
        end else if (item.drain_level == dtp_pkg::LVL_ERR_LOW) begin
          cmd                 = dtp_pkg::CMD_ON;
          nxt.error_low_count = cfg.error_low_min_on;
        end
        if (cur.prev_bin_full != item.bin_full) begin
          nxt.prev_bin_full = item.bin_full;
          if (item.bin_full && item.drain_level != dtp_pkg::LVL_LOW) begin
            cmd = dtp_pkg::CMD_ON;
          end
        end
        if (item.drain_level != dtp_pkg::LVL_MID) begin
          nxt.stale_count = cfg.stale_water_limit;
        end else if (cur.stale_count != 17'd0) begin
          nxt.stale_count = cur.stale_count - 17'd1;
        end else begin
          cmd = dtp_pkg::CMD_ON;
        end
      end else begin
        // pump running: stop rules
        nxt.stale_count = cfg.stale_water_limit;
        if (item.drain_level == dtp_pkg::LVL_LOW && cur.error_low_count == 10'd0) begin
          cmd = dtp_pkg::CMD_OFF;
        end else if (item.drain_level == dtp_pkg::LVL_MID ||
                     item.drain_level == dtp_pkg::LVL_LOW) begin
          if (!item.pump_loaded && cur.load_check_count == 10'd0) begin
            cmd = dtp_pkg::CMD_OFF;
          end
        end
        if (cur.error_low_count != 10'd0) begin
          nxt.error_low_count = cur.error_low_count - 10'd1;
        end
        if (cur.load_check_count != 10'd0) begin
          nxt.load_check_count = cur.load_check_count - 10'd1;
        end
      end
    end

    res.pump_command = cmd;
    res.init_done    = nxt.init_finished;
    res.level_seen   = nxt.stored_level;
  end

endmodule

>>> hdl/drain_tank_pump_controller.sv
// Drain tank pump controller, top level: handshakes, config and state registers.
// Depends on dtp_pkg and dtp_step.
//
// One transaction on the input channel is one control tick. The block takes a
// transaction every clock cycle while not stalled; each is captured in an input
// register, run through the tick logic in a single pass and written to the
// result register, so each tick passes the input register and then the result
// register, and the sustained rate is one transaction per cycle while the far
// side does not stall. The result register is the only output buffer: when the
// far side stalls, the tick holding in the input register waits and in_stall is
// raised. in_stall is also high during reset. Ticks are applied to the controller
// state in arrival order. The first 30 ticks after reset are a start-up hold:
// they give no pump command and do not store the level. Configuration registers
// are written through wr_en/wr_index/wr_data and should only be changed while no
// transaction is in flight; indexes past the last register are ignored.
module drain_tank_pump_controller (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      wr_en,
  input  logic [dtp_pkg::IDX_W-1:0] wr_index,
  input  logic [dtp_pkg::DATA_W-1:0] wr_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                drain_level,
  input  logic                      pump_is_on,
  input  logic                      pump_loaded,
  input  logic                      cold_low,
  input  logic                      room_low,
  input  logic                      bin_full,
  input  logic                      start_init,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                pump_command,
  output logic                      init_done,
  output logic [1:0]                level_seen
);

  dtp_pkg::cfg_t    cfg;
  dtp_pkg::state_t  state;
  dtp_pkg::state_t  state_next;
  dtp_pkg::item_t   stage_item;
  dtp_pkg::result_t step_res;
  dtp_pkg::result_t result;
  logic             stage_valid;
  logic             advance;
  logic             accept;

  // stage moves on when the result register is empty or being emptied
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = rst || (stage_valid && !advance);
  assign accept   = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ro_tank_mode      <= 1'b0;
      cfg.init_drain_limit  <= dtp_pkg::INIT_DRAIN_RESET;
      cfg.stale_water_limit <= dtp_pkg::STALE_LIMIT_RESET;
      cfg.error_low_min_on  <= dtp_pkg::ERR_LOW_MIN_RESET;
      cfg.load_check_min_on <= dtp_pkg::LOAD_CHECK_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        dtp_pkg::REG_RO_TANK_MODE:      cfg.ro_tank_mode      <= wr_data[0];
        dtp_pkg::REG_INIT_DRAIN_LIMIT:  cfg.init_drain_limit  <= wr_data[9:0];
        dtp_pkg::REG_STALE_WATER_LIMIT: cfg.stale_water_limit <= wr_data[16:0];
        dtp_pkg::REG_ERROR_LOW_MIN_ON:  cfg.error_low_min_on  <= wr_data[9:0];
        dtp_pkg::REG_LOAD_CHECK_MIN_ON: cfg.load_check_min_on <= wr_data[9:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.drain_level <= drain_level;
      stage_item.pump_is_on  <= pump_is_on;
      stage_item.pump_loaded <= pump_loaded;
      stage_item.cold_low    <= cold_low;
      stage_item.room_low    <= room_low;
      stage_item.bin_full    <= bin_full;
      stage_item.start_init  <= start_init;
    end
  end

  dtp_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (stage_item),
    .nxt  (state_next),
    .res  (step_res)
  );

  // controller state, committed as each tick leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.startup_hold     <= dtp_pkg::STARTUP_TICKS;
      state.init_finished    <= 1'b0;
      state.init_run_ticks   <= 10'd0;
      state.stored_level     <= dtp_pkg::LVL_LOW;
      state.stale_count      <= dtp_pkg::STALE_LIMIT_RESET;
      state.error_low_count  <= 10'd0;
      state.load_check_count <= 10'd0;
      state.prev_bin_full    <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

  assign pump_command = result.pump_command;
  assign init_done    = result.init_done;
  assign level_seen   = result.level_seen;

`ifndef SYNTHESIS
  // a tick inside the start-up hold never commands the pump
  assert property (@(posedge clk) disable iff (rst)
    (advance && state.startup_hold != 5'd0) |=> (pump_command == dtp_pkg::CMD_NONE))
    else $error("pump command issued during start-up hold");

  // the stored level is frozen during the start-up hold
  assert property (@(posedge clk) disable iff (rst)
    (advance && state.startup_hold != 5'd0) |=> $stable(state.stored_level))
    else $error("stored level changed during start-up hold");

  // state only changes when a tick leaves the input register
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("controller state changed without a tick");

  // only the defined command codes are produced
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pump_command == dtp_pkg::CMD_NONE || pump_command == dtp_pkg::CMD_ON ||
                   pump_command == dtp_pkg::CMD_OFF))
    else $error("invalid pump command code");
`endif

endmodule
